// ----- rtl/psc_pkg.sv -----
// Shared widths, register indexes and the calibration word bundle
// for the pressure sensor compensation block. No dependencies.
`default_nettype none

package psc_pkg;

  localparam int RAW_W       = 24;
  localparam int CAL_W       = 16;
  localparam int TEMP_W      = 19;
  localparam int PRES_W      = 32;
  localparam int ADDR_W      = 5;
  localparam int PIPE_STAGES = 9;
  localparam int TEMP_REF    = 2000;

  typedef enum logic [2:0] {
    REG_SENS_BASE         = 3'd0,
    REG_OFFSET_BASE       = 3'd1,
    REG_SENS_TEMP_COEFF   = 3'd2,
    REG_OFFSET_TEMP_COEFF = 3'd3,
    REG_REF_TEMPERATURE   = 3'd4,
    REG_TEMP_SLOPE        = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CAL_W-1:0] sens_base;
    logic [CAL_W-1:0] offset_base;
    logic [CAL_W-1:0] sens_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] ref_temperature;
    logic [CAL_W-1:0] temp_slope;
  } cal_t;

endpackage

`default_nettype wire

// ----- rtl/psc_datapath.sv -----
// Nine-stage compensation pipeline: first-order terms, low-temperature
// correction and the final pressure scaling. Depends on psc_pkg.
`default_nettype none

module psc_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire psc_pkg::cal_t                     cal,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [psc_pkg::RAW_W-1:0]         raw_pressure,
  input  wire logic [psc_pkg::RAW_W-1:0]         raw_temperature,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [psc_pkg::TEMP_W-1:0]      temperature_centi,
  output logic signed [psc_pkg::PRES_W-1:0]      pressure_centi
);

  import psc_pkg::*;

  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] en;

  // stage 1
  logic [RAW_W-1:0]   s1_d1;
  logic signed [24:0] s1_dt;
  // stage 2
  logic [RAW_W-1:0]   s2_d1;
  logic signed [40:0] s2_p4;
  logic signed [40:0] s2_p3;
  logic signed [40:0] s2_p6;
  logic [47:0]        s2_pdd;
  // stage 3
  logic [RAW_W-1:0]   s3_d1;
  logic signed [35:0] s3_off;
  logic signed [35:0] s3_sens;
  logic signed [17:0] s3_q;
  logic [16:0]        s3_ti;
  // stage 4
  logic [RAW_W-1:0]   s4_d1;
  logic signed [35:0] s4_off;
  logic signed [35:0] s4_sens;
  logic signed [TEMP_W-1:0] s4_temp;
  logic [16:0]        s4_ti;
  logic               s4_low;
  logic [33:0]        s4_ee;
  // stage 5
  logic [RAW_W-1:0]   s5_d1;
  logic signed [37:0] s5_off2;
  logic signed [37:0] s5_sens2;
  logic [TEMP_W-1:0]  s5_tout;
  // stage 6
  logic [42:0]        s6_pl;
  logic signed [42:0] s6_ph;
  logic signed [37:0] s6_off2;
  logic [TEMP_W-1:0]  s6_tout;
  // stage 7
  logic signed [61:0] s7_prod;
  logic signed [37:0] s7_off2;
  logic [TEMP_W-1:0]  s7_tout;
  // stage 8
  logic signed [41:0] s8_y;
  logic [TEMP_W-1:0]  s8_tout;

  // combinational terms
  logic signed [24:0] dt_next;
  logic signed [16:0] c4_s;
  logic signed [16:0] c3_s;
  logic signed [16:0] c6_s;
  logic signed [48:0] dt_sq;
  logic signed [40:0] p4_adj;
  logic signed [40:0] p3_adj;
  logic signed [40:0] p6_adj;
  logic signed [34:0] div4;
  logic signed [33:0] div3;
  logic [51:0]        m11;
  logic signed [35:0] qq;
  logic [38:0]        m31;
  logic [39:0]        m63;
  logic [35:0]        offi;
  logic [34:0]        sensi;
  logic signed [24:0] d1_s;
  logic signed [18:0] sens_hi;
  logic signed [42:0] ph_prod;
  logic signed [61:0] prod_adj;
  logic signed [40:0] div21;
  logic signed [41:0] y_adj;
  logic signed [26:0] div15;

  always_comb begin
    en[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || out_ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.ref_temperature, 8'd0});
    c4_s    = $signed({1'b0, cal.offset_temp_coeff});
    c3_s    = $signed({1'b0, cal.sens_temp_coeff});
    c6_s    = $signed({1'b0, cal.temp_slope});
    dt_sq   = s1_dt * s1_dt;

    p4_adj  = s2_p4 + $signed({35'd0, {6{s2_p4[40]}}});
    p3_adj  = s2_p3 + $signed({34'd0, {7{s2_p3[40]}}});
    p6_adj  = s2_p6 + $signed({18'd0, {23{s2_p6[40]}}});
    div4    = p4_adj[40:6];
    div3    = p3_adj[40:7];
    m11     = {1'b0, s2_pdd, 3'd0} + {3'd0, s2_pdd, 1'b0} + {4'd0, s2_pdd};

    qq      = s3_q * s3_q;

    m31     = {s4_ee, 5'd0} - {5'd0, s4_ee};
    m63     = {s4_ee, 6'd0} - {6'd0, s4_ee};
    offi    = m31[38:3];
    sensi   = m63[39:5];

    d1_s    = $signed({1'b0, s5_d1});
    sens_hi = s5_sens2[37:19];
    ph_prod = d1_s * sens_hi;

    prod_adj = s7_prod + $signed({41'd0, {21{s7_prod[61]}}});
    div21    = prod_adj[61:21];

    y_adj   = s8_y + $signed({27'd0, {15{s8_y[41]}}});
    div15   = y_adj[41:15];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_d1 <= raw_pressure;
      s1_dt <= dt_next;
    end
    if (en[1]) begin
      s2_d1  <= s1_d1;
      s2_p4  <= s1_dt * c4_s;
      s2_p3  <= s1_dt * c3_s;
      s2_p6  <= s1_dt * c6_s;
      s2_pdd <= dt_sq[47:0];
    end
    if (en[2]) begin
      s3_d1   <= s2_d1;
      s3_off  <= $signed({3'd0, cal.offset_base, 17'd0}) + 36'(div4);
      s3_sens <= $signed({4'd0, cal.sens_base, 16'd0}) + 36'(div3);
      s3_q    <= p6_adj[40:23];
      s3_ti   <= m11[51:35];
    end
    if (en[3]) begin
      s4_d1   <= s3_d1;
      s4_off  <= s3_off;
      s4_sens <= s3_sens;
      s4_temp <= TEMP_W'(TEMP_REF) + TEMP_W'(s3_q);
      s4_ti   <= s3_ti;
      s4_low  <= s3_q[17];
      s4_ee   <= qq[33:0];
    end
    if (en[4]) begin
      s5_d1    <= s4_d1;
      s5_off2  <= 38'(s4_off) - (s4_low ? $signed({2'd0, offi}) : 38'sd0);
      s5_sens2 <= 38'(s4_sens) - (s4_low ? $signed({3'd0, sensi}) : 38'sd0);
      s5_tout  <= s4_temp - (s4_low ? {2'd0, s4_ti} : '0);
    end
    if (en[5]) begin
      s6_pl   <= s5_d1 * s5_sens2[18:0];
      s6_ph   <= ph_prod;
      s6_off2 <= s5_off2;
      s6_tout <= s5_tout;
    end
    if (en[6]) begin
      s7_prod <= $signed({s6_ph, 19'd0}) + $signed({19'd0, s6_pl});
      s7_off2 <= s6_off2;
      s7_tout <= s6_tout;
    end
    if (en[7]) begin
      s8_y    <= 42'(div21) - 42'(s7_off2);
      s8_tout <= s7_tout;
    end
    if (en[8]) begin
      temperature_centi <= s8_tout;
      pressure_centi    <= PRES_W'(div15);
    end
  end

`ifndef NO_ASSERTIONS
  a_low_flag: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (s4_low == (s4_temp < TEMP_W'(TEMP_REF))))
    else $error("low-temperature flag disagrees with stage 4 temperature");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && !en[3]) |=> (vld[3] && $stable(s4_off) && $stable(s4_ee)))
    else $error("stalled stage 4 changed");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (vld == {PIPE_STAGES{1'b1}}))
    else $error("input held off with a bubble in the pipeline");
`endif

endmodule

`default_nettype wire

// ----- rtl/pressure_sensor_compensation_core.sv -----
// Top level: calibration register file on an APB-style port and the
// compensation pipeline. Depends on psc_pkg and psc_datapath.
`default_nettype none

// Takes one raw pressure/temperature conversion pair per request and returns
// temperature in 0.01 C and pressure in 0.01 mbar, with the low-temperature
// correction applied below 20.00 C. The datapath is a nine-stage pipeline:
// a pair enters every cycle while in_ready is high, and out_valid rises once
// the accepted request's result reaches the last stage register;
// per-stage valid bits let a stalled output fill bubbles upstream.
// The six calibration words sit at byte addresses 0x00..0x14; write them only
// while no request is in flight.

module pressure_sensor_compensation_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [psc_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [psc_pkg::RAW_W-1:0]         raw_pressure,
  input  wire logic [psc_pkg::RAW_W-1:0]         raw_temperature,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [psc_pkg::TEMP_W-1:0]      temperature_centi,
  output logic signed [psc_pkg::PRES_W-1:0]      pressure_centi
);

  import psc_pkg::*;

  cal_t     cal;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_SENS_BASE:         cal.sens_base         <= pwdata[CAL_W-1:0];
        REG_OFFSET_BASE:       cal.offset_base       <= pwdata[CAL_W-1:0];
        REG_SENS_TEMP_COEFF:   cal.sens_temp_coeff   <= pwdata[CAL_W-1:0];
        REG_OFFSET_TEMP_COEFF: cal.offset_temp_coeff <= pwdata[CAL_W-1:0];
        REG_REF_TEMPERATURE:   cal.ref_temperature   <= pwdata[CAL_W-1:0];
        REG_TEMP_SLOPE:        cal.temp_slope        <= pwdata[CAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SENS_BASE:         prdata = {16'd0, cal.sens_base};
      REG_OFFSET_BASE:       prdata = {16'd0, cal.offset_base};
      REG_SENS_TEMP_COEFF:   prdata = {16'd0, cal.sens_temp_coeff};
      REG_OFFSET_TEMP_COEFF: prdata = {16'd0, cal.offset_temp_coeff};
      REG_REF_TEMPERATURE:   prdata = {16'd0, cal.ref_temperature};
      REG_TEMP_SLOPE:        prdata = {16'd0, cal.temp_slope};
      default:               prdata = '0;
    endcase
  end

  psc_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cal               (cal),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .raw_pressure      (raw_pressure),
    .raw_temperature   (raw_temperature),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .temperature_centi (temperature_centi),
    .pressure_centi    (pressure_centi)
  );

endmodule

`default_nettype wire
